@@ hw/rtl/brrg_pkg.sv @@
// ----------------------------------------------------------------------------
// brrg_pkg
// Types, constants and small helpers for the bounded random range generator.
// ----------------------------------------------------------------------------
package brrg_pkg;

   // splitmix64 constants
   localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

   // result width codes
   localparam logic [1:0] SZ_8  = 2'd0;
   localparam logic [1:0] SZ_16 = 2'd1;
   localparam logic [1:0] SZ_32 = 2'd2;
   localparam logic [1:0] SZ_64 = 2'd3;

   // request commands
   localparam logic CMD_RAW     = 1'b0;
   localparam logic CMD_BOUNDED = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [1:0]  size_sel;
      logic        is_signed;
      logic [63:0] lower_bound;
      logic [63:0] upper_bound;
      logic        lower_exclusive;
      logic        upper_exclusive;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic        range_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_MUL,
      ST_ACC,
      ST_CHK1,
      ST_CHK2,
      ST_DRAW,
      ST_TEST,
      ST_DIV,
      ST_DONE
   } state_type;

   // who started the current multiply
   typedef enum logic [1:0] {
      CTX_SM1,
      CTX_SM2,
      CTX_LEM
   } ctx_type;

   function automatic logic [63:0] size_mask(input logic [1:0] s);
      logic [63:0] m;
      case (s)
         SZ_8:    m = 64'h0000_0000_0000_00ff;
         SZ_16:   m = 64'h0000_0000_0000_ffff;
         SZ_32:   m = 64'h0000_0000_ffff_ffff;
         default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [63:0] sign_bias(input logic [1:0] s);
      logic [63:0] b;
      case (s)
         SZ_8:    b = 64'h0000_0000_0000_0080;
         SZ_16:   b = 64'h0000_0000_0000_8000;
         SZ_32:   b = 64'h0000_0000_8000_0000;
         default: b = 64'h8000_0000_0000_0000;
      endcase
      return b;
   endfunction

   // top width bits of a generator output, zero extended
   function automatic logic [63:0] top_bits(input logic [63:0] r, input logic [1:0] s);
      logic [63:0] t;
      case (s)
         SZ_8:    t = {56'd0, r[63:56]};
         SZ_16:   t = {48'd0, r[63:48]};
         SZ_32:   t = {32'd0, r[63:32]};
         default: t = r;
      endcase
      return t;
   endfunction

   // integer part of the scaled product
   function automatic logic [63:0] lem_res(input logic [127:0] p, input logic [1:0] s);
      logic [63:0] t;
      case (s)
         SZ_8:    t = {56'd0, p[15:8]};
         SZ_16:   t = {48'd0, p[31:16]};
         SZ_32:   t = {32'd0, p[63:32]};
         default: t = p[127:64];
      endcase
      return t;
   endfunction

endpackage

@@ hw/rtl/bounded_random_range_generator.sv @@
// ----------------------------------------------------------------------------
// bounded_random_range_generator
// xoroshiro128** source with splitmix64 seeding and Lemire bounded draws.
// ----------------------------------------------------------------------------
// One request at a time; req_ready is high only while the sequencer idles.
// All wide products go through one 32x32 multiplier as four partial
// products, each a multiply state and an accumulate state. A bounded draw
// runs a bit-serial remainder the first time a fraction falls below the
// span; rejected samples repeat the draw. A seed write is taken at any clock
// edge and restarts seeding; it (and reset) runs two splitmix64 steps, during
// which no request is taken.
module bounded_random_range_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  brrg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output brrg_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [63:0]       csr_wdata
);

   brrg_pkg::state_type state_ff, state_in;
   brrg_pkg::ctx_type   ctx_ff, ctx_in;
   brrg_pkg::req_type   req_ff, req_in;
   brrg_pkg::rsp_type   out_ff, out_in, rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in, ctr_ff, ctr_in;
   logic [63:0]  opa_ff, opa_in, opb_ff, opb_in, p_ff, p_in;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   k_ff, k_in;
   logic         half_ff, half_in;
   logic [63:0]  lo_ff, lo_in, hi_ff, hi_in, span_ff, span_in;
   logic         err_ff, err_in;
   logic [63:0]  res_ff, res_in, frac_ff, frac_in, thr_ff, thr_in;
   logic         thr_valid_ff, thr_valid_in;
   logic [63:0]  rem_ff, rem_in, dvd_ff, dvd_in;
   logic [5:0]   cnt_ff, cnt_in;

   logic [63:0]  mask, bias, gn_r, gn_a, gn_b, s1, x5, ctr_nxt, z, lo_m, hi_m, sm_out;
   logic [127:0] pp_shift, acc_sum;
   logic [31:0]  mul_a, mul_b;
   logic [64:0]  trial;
   logic [63:0]  rem_nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brrg_pkg::ST_SEED;
         ctr_ff       <= 64'd0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_valid_ff <= thr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff  <= ctx_in;
      req_ff  <= req_in;
      out_ff  <= out_in;
      rsp_ff  <= rsp_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      p_ff    <= p_in;
      acc_ff  <= acc_in;
      k_ff    <= k_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      span_ff <= span_in;
      err_ff  <= err_in;
      res_ff  <= res_in;
      frac_ff <= frac_in;
      thr_ff  <= thr_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      cnt_ff  <= cnt_in;
   end

   // width helpers and generator step
   always_comb begin
      mask    = brrg_pkg::size_mask(req_ff.size_sel);
      bias    = req_ff.is_signed ? brrg_pkg::sign_bias(req_ff.size_sel) : 64'd0;
      s1      = b_ff ^ a_ff;
      x5      = a_ff + (a_ff << 2);
      gn_r    = {x5[56:0], x5[63:57]} + ({x5[56:0], x5[63:57]} << 3);
      gn_a    = {a_ff[39:0], a_ff[63:40]} ^ s1 ^ (s1 << 16);
      gn_b    = {s1[26:0], s1[63:27]};
      ctr_nxt = ctr_ff + brrg_pkg::SM_GAMMA;
      z       = ctr_nxt ^ (ctr_nxt >> 30);
      lo_m    = req_ff.lower_bound & mask;
      hi_m    = req_ff.upper_bound & mask;
      // shared multiplier operands and accumulation
      mul_a   = k_ff[1] ? opa_ff[63:32] : opa_ff[31:0];
      mul_b   = k_ff[0] ? opb_ff[63:32] : opb_ff[31:0];
      case (k_ff)
         2'd0:    pp_shift = {64'd0, p_ff};
         2'd3:    pp_shift = {p_ff, 64'd0};
         default: pp_shift = {32'd0, p_ff, 32'd0};
      endcase
      acc_sum = acc_ff + pp_shift;
      sm_out  = acc_sum[63:0] ^ (acc_sum[63:0] >> 31);
      // one restoring remainder step
      trial   = {rem_ff, dvd_ff[63]};
      rem_nxt = (trial >= {1'b0, span_ff}) ? 64'(trial - {1'b0, span_ff}) : trial[63:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      req_in       = req_ff;
      out_in       = out_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      a_in         = a_ff;
      b_in         = b_ff;
      ctr_in       = ctr_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      half_in      = half_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      span_in      = span_ff;
      err_in       = err_ff;
      res_in       = res_ff;
      frac_in      = frac_ff;
      thr_in       = thr_ff;
      thr_valid_in = thr_valid_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      req_ready    = (state_ff == brrg_pkg::ST_IDLE) && !csr_we;

      case (state_ff)
         brrg_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in   = req_data;
               state_in = brrg_pkg::ST_CHK1;
            end
         end
         // advance splitmix counter, start first multiply
         brrg_pkg::ST_SEED: begin
            ctr_in   = ctr_nxt;
            opa_in   = z;
            opb_in   = brrg_pkg::SM_MUL1;
            ctx_in   = brrg_pkg::CTX_SM1;
            acc_in   = 128'd0;
            k_in     = 2'd0;
            state_in = brrg_pkg::ST_MUL;
         end
         brrg_pkg::ST_MUL: begin
            p_in     = mul_a * mul_b;
            state_in = brrg_pkg::ST_ACC;
         end
         brrg_pkg::ST_ACC: begin
            acc_in = acc_sum;
            if (k_ff != 2'd3) begin
               k_in     = k_ff + 2'd1;
               state_in = brrg_pkg::ST_MUL;
            end else begin
               k_in   = 2'd0;
               acc_in = 128'd0;
               case (ctx_ff)
                  brrg_pkg::CTX_SM1: begin
                     opa_in   = acc_sum[63:0] ^ (acc_sum[63:0] >> 27);
                     opb_in   = brrg_pkg::SM_MUL2;
                     ctx_in   = brrg_pkg::CTX_SM2;
                     state_in = brrg_pkg::ST_MUL;
                  end
                  brrg_pkg::CTX_SM2: begin
                     if (!half_ff) begin
                        a_in     = sm_out;
                        half_in  = 1'b1;
                        state_in = brrg_pkg::ST_SEED;
                     end else begin
                        b_in     = sm_out;
                        state_in = brrg_pkg::ST_IDLE;
                     end
                  end
                  default: begin
                     res_in   = brrg_pkg::lem_res(acc_sum, req_ff.size_sel);
                     frac_in  = acc_sum[63:0] & mask;
                     state_in = brrg_pkg::ST_TEST;
                  end
               endcase
            end
         end
         // serve raw requests; else mask bounds, apply exclusive ends
         brrg_pkg::ST_CHK1: begin
            if (req_ff.cmd == brrg_pkg::CMD_RAW) begin
               a_in     = gn_a;
               b_in     = gn_b;
               out_in   = '{value: brrg_pkg::top_bits(gn_r, req_ff.size_sel), range_error: 1'b0};
               state_in = brrg_pkg::ST_DONE;
            end else begin
               err_in   = (req_ff.lower_exclusive && ((lo_m ^ bias) == mask)) ||
                          (req_ff.upper_exclusive && ((hi_m ^ bias) == 64'd0));
               lo_in    = req_ff.lower_exclusive ? ((lo_m + 64'd1) & mask) : lo_m;
               hi_in    = req_ff.upper_exclusive ? ((hi_m - 64'd1) & mask) : hi_m;
               state_in = brrg_pkg::ST_CHK2;
            end
         end
         // order check and span; a full-width span takes a raw sample
         brrg_pkg::ST_CHK2: begin
            span_in = (hi_ff - lo_ff + 64'd1) & mask;
            if (err_ff || ((lo_ff ^ bias) > (hi_ff ^ bias))) begin
               out_in   = '{value: 64'd0, range_error: 1'b1};
               state_in = brrg_pkg::ST_DONE;
            end else if (((hi_ff - lo_ff + 64'd1) & mask) == 64'd0) begin
               a_in     = gn_a;
               b_in     = gn_b;
               out_in   = '{value: brrg_pkg::top_bits(gn_r, req_ff.size_sel), range_error: 1'b0};
               state_in = brrg_pkg::ST_DONE;
            end else begin
               thr_valid_in = 1'b0;
               state_in     = brrg_pkg::ST_DRAW;
            end
         end
         // take a sample and scale it by the span
         brrg_pkg::ST_DRAW: begin
            a_in     = gn_a;
            b_in     = gn_b;
            opa_in   = brrg_pkg::top_bits(gn_r, req_ff.size_sel);
            opb_in   = span_ff;
            ctx_in   = brrg_pkg::CTX_LEM;
            acc_in   = 128'd0;
            k_in     = 2'd0;
            state_in = brrg_pkg::ST_MUL;
         end
         // accept or reject the sample, computing the threshold first if needed
         brrg_pkg::ST_TEST: begin
            if (frac_ff >= span_ff || (thr_valid_ff && frac_ff >= thr_ff)) begin
               out_in   = '{value: (lo_ff + res_ff) & mask, range_error: 1'b0};
               state_in = brrg_pkg::ST_DONE;
            end else if (!thr_valid_ff) begin
               rem_in   = 64'd0;
               dvd_in   = (64'd0 - span_ff) & mask;
               cnt_in   = 6'd0;
               state_in = brrg_pkg::ST_DIV;
            end else begin
               state_in = brrg_pkg::ST_DRAW;
            end
         end
         // rejection threshold, one remainder bit per cycle
         brrg_pkg::ST_DIV: begin
            rem_in = rem_nxt;
            dvd_in = {dvd_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               thr_in       = rem_nxt;
               thr_valid_in = 1'b1;
               state_in     = brrg_pkg::ST_TEST;
            end
         end
         // hold until the output register is free
         brrg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = out_ff;
               rsp_valid_in = 1'b1;
               state_in     = brrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brrg_pkg::ST_IDLE;
         end
      endcase

      // restart seeding on a seed write
      if (csr_we) begin
         ctr_in   = csr_wdata;
         half_in  = 1'b0;
         state_in = brrg_pkg::ST_SEED;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/brrg_checker.sv @@
// ----------------------------------------------------------------------------
// brrg_checker
// Port-level checks for the bounded random range generator.
// ----------------------------------------------------------------------------
module brrg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input brrg_pkg::rsp_type rsp_data,
   input logic              csr_we
);

   // error responses carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_error |-> rsp_data.value == 64'd0)
      else $error("range error with nonzero value");

   // busy right after a request is taken
   a_busy_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after request");

   // busy while reseeding
   a_busy_seed: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("ready during reseed");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

endmodule

bind bounded_random_range_generator brrg_checker u_brrg_checker (.*);
